FILE: design/earm_pkg.sv
`timescale 1ns / 1ps
// Package for the Euler angle rotation matrix block: payload structs,
// axis codes and fixed-point constants. No dependencies.
package earm_pkg;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_e;

  typedef struct packed {
    logic               mode;
    logic [1:0]         axis_first;
    logic [1:0]         axis_second;
    logic [1:0]         axis_third;
    logic signed [15:0] angle_first;
    logic signed [15:0] angle_second;
    logic signed [15:0] angle_third;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               bad_axis;
  } out_t;

  // per-item sideband in the sine/cosine pipeline
  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [27:0] x;
    logic [27:0] x2;
  } side_t;

  // axis codes after the Euler swap
  typedef struct packed {
    logic [2:0][1:0] ax;
    logic            bad;
  } axes_t;

  localparam logic [16:0] TURN_OFS      = 17'd46080;
  localparam logic [16:0] TURN_1        = 17'd23040;
  localparam logic [16:0] TURN_2        = 17'd46080;
  localparam logic [16:0] TURN_3        = 17'd69120;
  localparam logic [14:0] QUARTER_1     = 15'd5760;
  localparam logic [14:0] QUARTER_2     = 15'd11520;
  localparam logic [14:0] QUARTER_3     = 15'd17280;
  localparam logic [12:0] QUARTER_UNITS = 13'd5760;
  localparam logic [12:0] EIGHTH_UNITS  = 13'd2880;
  localparam logic [39:0] DEG_TO_RAD    = 40'd73204;
  localparam logic [28:0] Q28_ONE       = 29'h1000_0000;
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  localparam longint unsigned SIN_DIV [3] = '{64'd42, 64'd20, 64'd6};
  localparam longint unsigned COS_DIV [4] = '{64'd56, 64'd30, 64'd12, 64'd2};

endpackage

FILE: design/euler_angle_rotation_matrix_top.sv
`timescale 1ns / 1ps
// Rotation matrix R = R3*R2*R1 from three axis/angle pairs, fixed or Euler order.
// Depends on earm_pkg and earm_sincos.
// Accepts one transfer per cycle while the output is not stalled; each matrix
// passes through 17 stages of sine/cosine (angle reduction, Taylor series in
// Horner form with reciprocal-multiply division) and 5 stages of the triple
// matrix product with rounding and saturation. A stall on the output freezes
// the whole pipeline and is passed straight back to the input.
module euler_angle_rotation_matrix_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  earm_pkg::in_t in_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output earm_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_stall_i
);
  import earm_pkg::*;

  localparam int SC_LAT = 17;
  localparam int LAST   = 22;

  logic        en;
  logic        vld_q [1:LAST];
  axes_t       ax_d;
  axes_t       ax_q [1:SC_LAT];
  logic signed [15:0] sn [3];
  logic signed [15:0] cs [3];
  logic signed [15:0] e  [3][3][3];
  logic signed [15:0] e3_q1 [3][3];
  logic signed [15:0] e3_q2 [3][3];
  logic signed [31:0] p1_q  [3][3][3];
  logic signed [33:0] m_q   [3][3];
  logic signed [49:0] p2_q  [3][3][3];
  logic signed [51:0] acc_q [3][3];
  logic               bad_q [18:21];
  logic signed [51:0] sh    [3][3];
  logic signed [15:0] res   [3][3];
  out_t               out_q;

  assign en          = !(vld_q[LAST] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAST];
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 1; n <= LAST; n++) begin
        vld_q[n] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int n = 2; n <= LAST; n++) begin
        vld_q[n] <= vld_q[n-1];
      end
    end
  end

  always_comb begin
    ax_d.ax[0] = in_i.mode ? in_i.axis_third : in_i.axis_first;
    ax_d.ax[1] = in_i.axis_second;
    ax_d.ax[2] = in_i.mode ? in_i.axis_first : in_i.axis_third;
    ax_d.bad   = (in_i.axis_first == AXIS_BAD) || (in_i.axis_second == AXIS_BAD) ||
                 (in_i.axis_third == AXIS_BAD);
  end

  earm_sincos u_sc0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(in_i.angle_first),
    .sin_o  (sn[0]),
    .cos_o  (cs[0])
  );

  earm_sincos u_sc1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(in_i.angle_second),
    .sin_o  (sn[1]),
    .cos_o  (cs[1])
  );

  earm_sincos u_sc2 (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(in_i.angle_third),
    .sin_o  (sn[2]),
    .cos_o  (cs[2])
  );

  // elementary matrices, row-major
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          e[a][i][j] = '0;
        end
      end
      case (ax_q[SC_LAT].ax[a])
        AXIS_X: begin
          e[a][0][0] = Q14_ONE;
          e[a][1][1] = cs[a];
          e[a][1][2] = -sn[a];
          e[a][2][1] = sn[a];
          e[a][2][2] = cs[a];
        end
        AXIS_Y: begin
          e[a][0][0] = cs[a];
          e[a][0][2] = sn[a];
          e[a][1][1] = Q14_ONE;
          e[a][2][0] = -sn[a];
          e[a][2][2] = cs[a];
        end
        default: begin
          e[a][0][0] = cs[a];
          e[a][0][1] = -sn[a];
          e[a][1][0] = sn[a];
          e[a][1][1] = cs[a];
          e[a][2][2] = Q14_ONE;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int l = 0; l < 3; l++) begin
        sh[i][l] = (acc_q[i][l] + 52'sd134217728) >>> 28;
        if (bad_q[21]) begin
          res[i][l] = '0;
        end else if (sh[i][l] > 52'sd16384) begin
          res[i][l] = Q14_ONE;
        end else if (sh[i][l] < -52'sd16384) begin
          res[i][l] = -Q14_ONE;
        end else begin
          res[i][l] = 16'(sh[i][l]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q[1] <= ax_d;
      for (int n = 2; n <= SC_LAT; n++) begin
        ax_q[n] <= ax_q[n-1];
      end
      bad_q[18] <= ax_q[SC_LAT].bad;
      for (int n = 19; n <= 21; n++) begin
        bad_q[n] <= bad_q[n-1];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          e3_q1[i][j] <= e[2][i][j];
          e3_q2[i][j] <= e3_q1[i][j];
          for (int k = 0; k < 3; k++) begin
            p1_q[i][j][k] <= e[1][i][k] * e[0][k][j];
            p2_q[i][j][k] <= 50'(e3_q2[i][k]) * 50'(m_q[k][j]);
          end
          m_q[i][j]   <= 34'(p1_q[i][j][0]) + 34'(p1_q[i][j][1]) + 34'(p1_q[i][j][2]);
          acc_q[i][j] <= 52'(p2_q[i][j][0]) + 52'(p2_q[i][j][1]) + 52'(p2_q[i][j][2]);
        end
      end
      out_q.m00      <= res[0][0];
      out_q.m01      <= res[0][1];
      out_q.m02      <= res[0][2];
      out_q.m10      <= res[1][0];
      out_q.m11      <= res[1][1];
      out_q.m12      <= res[1][2];
      out_q.m20      <= res[2][0];
      out_q.m21      <= res[2][1];
      out_q.m22      <= res[2][2];
      out_q.bad_axis <= bad_q[21];
    end
  end

endmodule

FILE: design/earm_sincos.sv
`timescale 1ns / 1ps
// Pipelined sine and cosine in Q1.14 of an angle in 1/64 degree units.
// Seventeen register stages, all advanced by en_i. Depends on earm_pkg.
module earm_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  import earm_pkg::*;

  logic signed [17:0] vs;
  logic [16:0]        v;
  logic [14:0]        r_d, r_q;
  logic [1:0]         quad_d, quad_q;
  logic [12:0]        f_d;
  logic               swap_d, swap_q;
  logic [11:0]        g_d, g_q;
  side_t              side_q [3:16];

  logic [28:0] sin_t_q  [3];
  logic [27:0] sin_p_q  [3];
  logic [27:0] sin_p2_q [3];
  logic [27:0] sin_q0_q [3];
  logic [28:0] cos_t_q  [4];
  logic [27:0] cos_p_q  [4];
  logic [27:0] cos_p2_q [4];
  logic [27:0] cos_q0_q [4];

  logic [27:0] sin_x_q, sin_d1_q, sin_d2_q;
  logic signed [15:0] s0, c0, s, c;
  logic signed [15:0] sin_q, cos_q;

  assign vs = 18'(angle_i) + 18'(TURN_OFS);
  assign v  = vs[16:0];

  always_comb begin
    if (v >= TURN_3) begin
      r_d = 15'(v - TURN_3);
    end else if (v >= TURN_2) begin
      r_d = 15'(v - TURN_2);
    end else if (v >= TURN_1) begin
      r_d = 15'(v - TURN_1);
    end else begin
      r_d = 15'(v);
    end
  end

  always_comb begin
    if (r_q >= QUARTER_3) begin
      quad_d = 2'd3;
      f_d    = 13'(r_q - QUARTER_3);
    end else if (r_q >= QUARTER_2) begin
      quad_d = 2'd2;
      f_d    = 13'(r_q - QUARTER_2);
    end else if (r_q >= QUARTER_1) begin
      quad_d = 2'd1;
      f_d    = 13'(r_q - QUARTER_1);
    end else begin
      quad_d = 2'd0;
      f_d    = 13'(r_q);
    end
    swap_d = f_d > EIGHTH_UNITS;
    g_d    = swap_d ? 12'(QUARTER_UNITS - f_d) : 12'(f_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q          <= r_d;
      quad_q       <= quad_d;
      swap_q       <= swap_d;
      g_q          <= g_d;
      side_q[3].quad <= quad_q;
      side_q[3].swap <= swap_q;
      side_q[3].x    <= 28'(40'(g_q) * DEG_TO_RAD);
      side_q[3].x2   <= '0;
      side_q[4].quad <= side_q[3].quad;
      side_q[4].swap <= side_q[3].swap;
      side_q[4].x    <= side_q[3].x;
      side_q[4].x2   <= 28'((56'(side_q[3].x) * 56'(side_q[3].x)) >> 28);
      for (int n = 5; n <= 16; n++) begin
        side_q[n] <= side_q[n-1];
      end
    end
  end

  // Horner step: t' = 1 - floor(((x2 * t) >> 28) / d), three stages each
  for (genvar k = 0; k < 3; k++) begin : g_sin
    localparam int              Base = 4 + 3 * k;
    localparam longint unsigned Div  = SIN_DIV[k];
    localparam longint unsigned Rcp  = (64'd1 << 32) / Div;
    logic [28:0] t_in;
    logic [27:0] rem;
    if (k == 0) begin : g_first
      assign t_in = Q28_ONE;
    end else begin : g_next
      assign t_in = sin_t_q[k-1];
    end
    assign rem = sin_p2_q[k] - 28'(64'(sin_q0_q[k]) * Div);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sin_p_q[k]  <= 28'((57'(side_q[Base].x2) * 57'(t_in)) >> 28);
        sin_p2_q[k] <= sin_p_q[k];
        sin_q0_q[k] <= 28'((64'(sin_p_q[k]) * Rcp) >> 32);
        sin_t_q[k]  <= Q28_ONE - 29'(sin_q0_q[k]) - 29'(rem >= 28'(Div));
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_cos
    localparam int              Base = 4 + 3 * k;
    localparam longint unsigned Div  = COS_DIV[k];
    localparam longint unsigned Rcp  = (64'd1 << 32) / Div;
    logic [28:0] t_in;
    logic [27:0] rem;
    if (k == 0) begin : g_first
      assign t_in = Q28_ONE;
    end else begin : g_next
      assign t_in = cos_t_q[k-1];
    end
    assign rem = cos_p2_q[k] - 28'(64'(cos_q0_q[k]) * Div);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cos_p_q[k]  <= 28'((57'(side_q[Base].x2) * 57'(t_in)) >> 28);
        cos_p2_q[k] <= cos_p_q[k];
        cos_q0_q[k] <= 28'((64'(cos_p_q[k]) * Rcp) >> 32);
        cos_t_q[k]  <= Q28_ONE - 29'(cos_q0_q[k]) - 29'(rem >= 28'(Div));
      end
    end
  end

  always_comb begin
    s0 = 16'((29'(sin_d2_q) + 29'd8192) >> 14);
    c0 = 16'((30'(cos_t_q[3]) + 30'd8192) >> 14);
    s  = side_q[16].swap ? c0 : s0;
    c  = side_q[16].swap ? s0 : c0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_x_q  <= 28'((57'(side_q[13].x) * 57'(sin_t_q[2])) >> 28);
      sin_d1_q <= sin_x_q;
      sin_d2_q <= sin_d1_q;
      case (side_q[16].quad)
        2'd0: begin
          sin_q <= s;
          cos_q <= c;
        end
        2'd1: begin
          sin_q <= c;
          cos_q <= -s;
        end
        2'd2: begin
          sin_q <= -s;
          cos_q <= -c;
        end
        default: begin
          sin_q <= -c;
          cos_q <= s;
        end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
